/* sv/nectx_pkg.sv */
// Package with the shared types, codes and constants of the NEC IR frame transmitter.
package nectx_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned KEY_W   = 3;
  localparam int unsigned REG_W   = 2;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned HIGH_W  = 5;
  localparam int unsigned LOW_W   = 4;

  localparam logic [HIGH_W-1:0] LEADER_HIGH_TICKS = HIGH_W'(16);
  localparam logic [LOW_W-1:0]  LEADER_LOW_TICKS  = LOW_W'(8);
  localparam logic [LOW_W-1:0]  ONE_LOW_TICKS     = LOW_W'(3);
  localparam logic [POS_W-1:0]  DATA_BITS         = POS_W'(32);
  localparam logic [POS_W-1:0]  FINAL_POS         = POS_W'(33);

  localparam logic [WORD_W-1:0] RST_WORD_VOLUME_UP   = 32'hEB147286;
  localparam logic [WORD_W-1:0] RST_WORD_VOLUME_DOWN = 32'hEA157286;
  localparam logic [WORD_W-1:0] RST_WORD_TRACK_UP    = 32'hED127286;
  localparam logic [WORD_W-1:0] RST_WORD_TRACK_DOWN  = 32'hEC137286;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_KEY  = 1'b1
  } opcode_t;

  typedef enum logic [KEY_W-1:0] {
    KEY_NONE     = 3'd0,
    KEY_VOL_UP   = 3'd1,
    KEY_VOL_DOWN = 3'd2,
    KEY_TRK_UP   = 3'd3,
    KEY_TRK_DOWN = 3'd4,
    KEY_REPEAT   = 3'd5
  } key_t;

  typedef enum logic [REG_W-1:0] {
    REG_WORD_VOLUME_UP   = 2'd0,
    REG_WORD_VOLUME_DOWN = 2'd1,
    REG_WORD_TRACK_UP    = 2'd2,
    REG_WORD_TRACK_DOWN  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic             opcode;
    logic [KEY_W-1:0] key_code;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0] vol_up;
    logic [WORD_W-1:0] vol_down;
    logic [WORD_W-1:0] trk_up;
    logic [WORD_W-1:0] trk_down;
  } key_words_t;

  typedef struct packed {
    logic line_level;
    logic busy;
  } status_t;

endpackage

/* sv/nectx_in_if.sv */
// Input channel interface: tick or key request words.
interface nectx_in_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [nectx_pkg::KEY_W-1:0]   key_code;

  modport source (output valid, output opcode, output key_code, input ready);
  modport sink   (input valid, input opcode, input key_code, output ready);
endinterface

/* sv/nectx_out_if.sv */
// Result channel interface: line level and busy flag.
interface nectx_out_if;
  logic valid;
  logic ready;
  logic line_level;
  logic busy_res;

  modport source (output valid, output line_level, output busy_res, input ready);
  modport sink   (input valid, input line_level, input busy_res, output ready);
endinterface

/* sv/nectx_cfg_if.sv */
// Configuration write channel interface: register index and write data.
interface nectx_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [nectx_pkg::REG_W-1:0]    index;
  logic [nectx_pkg::WORD_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/nec_ir_frame_transmitter_top.sv */
// Top level of the NEC IR frame transmitter: input register, config words, result register.
// An accepted word is held in the input register, then its status in the result register.
// Throughput: one word per cycle while the result channel is ready; single-pass sequencer.
// The input register takes one more word while a result waits to be taken.
// Reset (synchronous, rst_n low) idles the line, clears all words and loads the key words.
module nec_ir_frame_transmitter_top (
  input logic       clk,
  input logic       rst_n,
  nectx_in_if.sink  in_ch,
  nectx_out_if.source out_ch,
  nectx_cfg_if.sink cfg_ch
);
  import nectx_pkg::*;

  logic       in_valid_r;
  item_t      in_item_r;
  logic       out_valid_r;
  status_t    out_stat_r;
  logic       adv;
  logic       step;
  key_words_t words_r;
  status_t    stat;

  assign adv          = !out_valid_r || out_ch.ready;
  assign step         = adv && in_valid_r;
  assign in_ch.ready  = !in_valid_r || adv;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_item_r.opcode   <= in_ch.opcode;
      in_item_r.key_code <= in_ch.key_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      words_r.vol_up   <= RST_WORD_VOLUME_UP;
      words_r.vol_down <= RST_WORD_VOLUME_DOWN;
      words_r.trk_up   <= RST_WORD_TRACK_UP;
      words_r.trk_down <= RST_WORD_TRACK_DOWN;
    end else if (cfg_ch.valid) begin
      unique case (reg_idx_t'(cfg_ch.index))
        REG_WORD_VOLUME_UP:   words_r.vol_up   <= cfg_ch.data;
        REG_WORD_VOLUME_DOWN: words_r.vol_down <= cfg_ch.data;
        REG_WORD_TRACK_UP:    words_r.trk_up   <= cfg_ch.data;
        REG_WORD_TRACK_DOWN:  words_r.trk_down <= cfg_ch.data;
        default:              words_r          <= words_r;
      endcase
    end
  end

  nectx_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (in_item_r),
    .words  (words_r),
    .status (stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_stat_r <= stat;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.line_level = out_stat_r.line_level;
  assign out_ch.busy_res   = out_stat_r.busy;

endmodule

/* sv/nectx_engine.sv */
// Frame sequencer: pending, current and last words, tick counters and line state.
module nectx_engine (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  nectx_pkg::item_t       item,
  input  nectx_pkg::key_words_t  words,
  output nectx_pkg::status_t     status
);
  import nectx_pkg::*;

  logic [WORD_W-1:0] pend_r, pend_nxt;
  logic [WORD_W-1:0] cur_r, cur_nxt;
  logic [WORD_W-1:0] last_r, last_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [HIGH_W-1:0] high_r, high_nxt;
  logic [LOW_W-1:0]  low_r, low_nxt;
  logic              line_r, line_nxt;

  logic [POS_W-1:0]  pos_inc;
  logic [4:0]        bit_idx;
  logic              req;
  logic [WORD_W-1:0] req_word;

  assign pos_inc = pos_r + POS_W'(1);
  assign bit_idx = pos_inc[4:0] - 5'd1;

  always_comb begin
    req      = 1'b1;
    req_word = '0;
    case (key_t'(item.key_code))
      KEY_VOL_UP:   req_word = words.vol_up;
      KEY_VOL_DOWN: req_word = words.vol_down;
      KEY_TRK_UP:   req_word = words.trk_up;
      KEY_TRK_DOWN: req_word = words.trk_down;
      KEY_REPEAT:   req_word = last_r;
      default:      req      = 1'b0;
    endcase
  end

  always_comb begin
    pend_nxt = pend_r;
    cur_nxt  = cur_r;
    last_nxt = last_r;
    pos_nxt  = pos_r;
    high_nxt = high_r;
    low_nxt  = low_r;
    line_nxt = line_r;
    if (step) begin
      if (opcode_t'(item.opcode) == OP_KEY) begin
        if (req) begin
          pend_nxt = req_word;
          last_nxt = req_word;
        end
      end else if (cur_r == '0) begin
        // Idle line: start the pending word with its leader.
        if (pend_r != '0) begin
          cur_nxt  = pend_r;
          pend_nxt = '0;
          line_nxt = 1'b1;
          high_nxt = LEADER_HIGH_TICKS;
          low_nxt  = LEADER_LOW_TICKS;
          pos_nxt  = '0;
        end
      end else if (high_r != '0) begin
        high_nxt = high_r - HIGH_W'(1);
        if (high_r == HIGH_W'(1)) begin
          line_nxt = 1'b0;
        end
      end else if (low_r != '0) begin
        low_nxt = low_r - LOW_W'(1);
        if (low_r == LOW_W'(1)) begin
          if (pos_inc <= FINAL_POS) begin
            // Next data bit, or the closing pulse after the last bit.
            pos_nxt  = pos_inc;
            line_nxt = 1'b1;
            high_nxt = HIGH_W'(1);
            if (pos_inc == FINAL_POS || !cur_r[bit_idx]) begin
              low_nxt = LOW_W'(1);
            end else begin
              low_nxt = ONE_LOW_TICKS;
            end
          end else begin
            high_nxt = '0;
            low_nxt  = '0;
            cur_nxt  = '0;
            pos_nxt  = '0;
          end
        end
      end
    end
  end

  assign status.line_level = line_nxt;
  assign status.busy       = (cur_nxt != '0) || (pend_nxt != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      cur_r  <= '0;
      last_r <= '0;
      pos_r  <= '0;
      high_r <= '0;
      low_r  <= '0;
      line_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      cur_r  <= cur_nxt;
      last_r <= last_nxt;
      pos_r  <= pos_nxt;
      high_r <= high_nxt;
      low_r  <= low_nxt;
      line_r <= line_nxt;
    end
  end

`ifndef SYNTHESIS
  a_line_needs_frame: assert property (@(posedge clk) disable iff (!rst_n)
    line_r |-> (cur_r != '0))
    else $error("line high without an active frame");

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= FINAL_POS)
    else $error("bit position past the closing pulse");

  a_active_has_ticks: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_r != '0) |-> ((high_r != '0) || (low_r != '0)))
    else $error("active frame with no ticks left");

  a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
    (step && item.opcode == OP_TICK && cur_r == '0 && pend_r != '0)
      |=> (line_r && pend_r == '0 && high_r == LEADER_HIGH_TICKS))
    else $error("pending word did not start a leader");
`endif

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the NEC IR frame transmitter top level.
`timescale 1ns / 1ps

module tb_top;
  import nectx_pkg::*;

  localparam logic [KEY_W-1:0]  KEY_UNDEF_6  = 3'd6;
  localparam logic [KEY_W-1:0]  KEY_UNDEF_7  = 3'd7;
  localparam logic [WORD_W-1:0] TRK_UP_MAX   = 32'hFFF17286;
  localparam int unsigned       IDLE_SETTLE  = 4;
  localparam int unsigned       LONG_HOLD_AT = 300;
  localparam int unsigned       LONG_HOLD    = 400;

  localparam status_t ST_IDLE  = '{line_level: 1'b0, busy: 1'b0};
  localparam status_t ST_PEND  = '{line_level: 1'b0, busy: 1'b1};
  localparam status_t ST_BURST = '{line_level: 1'b1, busy: 1'b1};

  typedef struct packed {
    opcode_t          op;
    logic [KEY_W-1:0] key;
    logic             typed;
    status_t          want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  nectx_in_if  in_ch();
  nectx_out_if out_ch();
  nectx_cfg_if cfg_ch();

  nec_ir_frame_transmitter_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  // Predicted transmitter state.
  logic [WORD_W-1:0] key_word [4];
  logic [WORD_W-1:0] tx_pending;
  logic [WORD_W-1:0] tx_current;
  logic [WORD_W-1:0] tx_last;
  logic [POS_W-1:0]  tx_pos;
  logic [HIGH_W-1:0] tx_high;
  logic [LOW_W-1:0]  tx_low;
  logic              tx_line;

  status_t     line_status_q [$];
  int unsigned results_seen = 0;
  int unsigned fail_count = 0;
  int unsigned in_nogap_left = 0;

  // An idle tick, then keys of every code, then a tick that starts the leader and a key during it.
  dir_row_t dir_rows [24] = '{
    '{OP_TICK, KEY_NONE,     1'b1, ST_IDLE},
    '{OP_KEY,  KEY_NONE,     1'b1, ST_IDLE},
    '{OP_KEY,  KEY_UNDEF_6,  1'b1, ST_IDLE},
    '{OP_KEY,  KEY_UNDEF_7,  1'b1, ST_IDLE},
    '{OP_KEY,  KEY_REPEAT,   1'b1, ST_IDLE},
    '{OP_KEY,  KEY_VOL_UP,   1'b1, ST_PEND},
    '{OP_KEY,  KEY_VOL_DOWN, 1'b1, ST_PEND},
    '{OP_KEY,  KEY_TRK_UP,   1'b1, ST_PEND},
    '{OP_KEY,  KEY_TRK_DOWN, 1'b1, ST_PEND},
    '{OP_KEY,  KEY_REPEAT,   1'b1, ST_PEND},
    '{OP_TICK, KEY_NONE,     1'b1, ST_BURST},
    '{OP_KEY,  KEY_VOL_UP,   1'b1, ST_BURST},
    '{OP_TICK, KEY_UNDEF_7,  1'b0, ST_IDLE},
    '{OP_TICK, KEY_NONE,     1'b0, ST_IDLE},
    '{OP_TICK, KEY_UNDEF_7,  1'b0, ST_IDLE},
    '{OP_TICK, KEY_NONE,     1'b0, ST_IDLE},
    '{OP_TICK, KEY_UNDEF_7,  1'b0, ST_IDLE},
    '{OP_TICK, KEY_NONE,     1'b0, ST_IDLE},
    '{OP_TICK, KEY_UNDEF_7,  1'b0, ST_IDLE},
    '{OP_TICK, KEY_NONE,     1'b0, ST_IDLE},
    '{OP_TICK, KEY_UNDEF_7,  1'b0, ST_IDLE},
    '{OP_TICK, KEY_NONE,     1'b0, ST_IDLE},
    '{OP_TICK, KEY_UNDEF_7,  1'b0, ST_IDLE},
    '{OP_TICK, KEY_NONE,     1'b0, ST_IDLE}
  };

  task automatic flag_error(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    fail_count++;
  endtask

  function automatic void queue_word(logic [WORD_W-1:0] w);
    tx_last    = w;
    tx_pending = w;
  endfunction

  function automatic status_t predict_status(opcode_t op, logic [KEY_W-1:0] key);
    status_t st;
    if (op == OP_TICK) begin
      if (tx_current == '0) begin
        if (tx_pending != '0) begin
          tx_current = tx_pending;
          tx_pending = '0;
          tx_line    = 1'b1;
          tx_high    = LEADER_HIGH_TICKS;
          tx_low     = LEADER_LOW_TICKS;
          tx_pos     = '0;
        end
      end else if (tx_high != '0) begin
        tx_high = tx_high - 1'b1;
        if (tx_high == '0) tx_line = 1'b0;
      end else if (tx_low != '0) begin
        tx_low = tx_low - 1'b1;
        if (tx_low == '0) begin
          tx_pos = tx_pos + 1'b1;
          if (tx_pos >= 1 && tx_pos <= FINAL_POS) begin
            // Every data bit and the closing pulse start with one tick of burst.
            tx_line = 1'b1;
            tx_high = HIGH_W'(1);
            if (tx_pos == FINAL_POS || !tx_current[5'(tx_pos - 1'b1)]) tx_low = LOW_W'(1);
            else tx_low = ONE_LOW_TICKS;
          end else begin
            tx_high    = '0;
            tx_low     = '0;
            tx_current = '0;
            tx_pos     = '0;
          end
        end
      end
    end else begin
      case (key)
        KEY_VOL_UP:   queue_word(key_word[REG_WORD_VOLUME_UP]);
        KEY_VOL_DOWN: queue_word(key_word[REG_WORD_VOLUME_DOWN]);
        KEY_TRK_UP:   queue_word(key_word[REG_WORD_TRACK_UP]);
        KEY_TRK_DOWN: queue_word(key_word[REG_WORD_TRACK_DOWN]);
        KEY_REPEAT:   queue_word(tx_last);
        default: ;
      endcase
    end
    st.line_level = tx_line;
    st.busy       = (tx_current != '0) || (tx_pending != '0);
    return st;
  endfunction

  function automatic int unsigned next_in_gap();
    int unsigned r;
    if (in_nogap_left > 0) begin
      in_nogap_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 8) begin
      in_nogap_left = $urandom_range(20, 100);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offers one word, records its expected status, then idles for a random gap.
  task automatic send_item(opcode_t op, logic [KEY_W-1:0] key, logic typed, status_t want);
    status_t     st;
    int unsigned gap;
    in_ch.valid    <= 1'b1;
    in_ch.opcode   <= op;
    in_ch.key_code <= key;
    do @(posedge clk); while (!in_ch.ready);
    st = predict_status(op, key);
    line_status_q.push_back(typed ? want : st);
    gap = next_in_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (line_status_q.size() != 0);
  endtask

  task automatic set_key_words(key_words_t w);
    logic [WORD_W-1:0] val [4];
    val[REG_WORD_VOLUME_UP]   = w.vol_up;
    val[REG_WORD_VOLUME_DOWN] = w.vol_down;
    val[REG_WORD_TRACK_UP]    = w.trk_up;
    val[REG_WORD_TRACK_DOWN]  = w.trk_down;
    for (int i = 0; i < 4; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= reg_idx_t'(i);
      cfg_ch.data  <= val[i];
      do @(posedge clk); while (!cfg_ch.ready);
      key_word[i] = val[i];
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly a key followed by a run of mostly ticks, of random length that may or may not finish a frame;
  // the rest is short bursts of mixed keys and ticks.
  task automatic run_random(int unsigned n);
    int unsigned      counted, run_len, key_pct;
    opcode_t          op;
    logic [KEY_W-1:0] key;
    counted = 0;
    while (counted < n) begin
      if ($urandom_range(0, 99) < 3) drain_results();
      if ($urandom_range(0, 99) < 75) begin
        key = KEY_W'($urandom_range(KEY_VOL_UP, KEY_REPEAT));
        send_item(OP_KEY, key, 1'b0, ST_IDLE);
        counted++;
        run_len = $urandom_range(10, 170);
        key_pct = 3;
      end else begin
        run_len = $urandom_range(1, 12);
        key_pct = 50;
      end
      repeat (run_len) begin
        op  = ($urandom_range(0, 99) < key_pct) ? OP_KEY : OP_TICK;
        key = KEY_W'($urandom());
        send_item(op, key, 1'b0, ST_IDLE);
        if (op == OP_TICK || (key >= KEY_VOL_UP && key <= KEY_REPEAT)) counted++;
      end
    end
  endtask

  initial begin : status_sink
    int unsigned hold_left, open_left, r;
    bit          long_hold_done;
    status_t     want;
    hold_left      = 0;
    open_left      = 0;
    long_hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (line_status_q.size() == 0) begin
          flag_error($sformatf("unexpected status word %0d", results_seen));
        end else begin
          want = line_status_q.pop_front();
          if (out_ch.line_level !== want.line_level)
            flag_error($sformatf("word %0d line_level got %b expected %b",
                                 results_seen, out_ch.line_level, want.line_level));
          if (out_ch.busy_res !== want.busy)
            flag_error($sformatf("word %0d busy_res got %b expected %b",
                                 results_seen, out_ch.busy_res, want.busy));
        end
        results_seen++;
      end
      // One long hold-off so that the block fills up and stalls its input.
      if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
        long_hold_done = 1'b1;
        hold_left      = LONG_HOLD;
        open_left      = 0;
      end
      if (hold_left == 0 && open_left == 0) begin
        r = $urandom_range(0, 99);
        if (r < 10) open_left = $urandom_range(20, 80);
        else if (r < 55) open_left = 1;
        else if (r < 95) hold_left = $urandom_range(1, 3);
        else hold_left = $urandom_range(10, 40);
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= 1'b1;
        open_left--;
      end
    end
  end

  initial begin : stimulus
    key_words_t w;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.opcode   <= OP_TICK;
    in_ch.key_code <= KEY_NONE;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= REG_WORD_VOLUME_UP;
    cfg_ch.data    <= '0;

    key_word[REG_WORD_VOLUME_UP]   = RST_WORD_VOLUME_UP;
    key_word[REG_WORD_VOLUME_DOWN] = RST_WORD_VOLUME_DOWN;
    key_word[REG_WORD_TRACK_UP]    = RST_WORD_TRACK_UP;
    key_word[REG_WORD_TRACK_DOWN]  = RST_WORD_TRACK_DOWN;
    tx_pending = '0;
    tx_current = '0;
    tx_last    = '0;
    tx_pos     = '0;
    tx_high    = '0;
    tx_low     = '0;
    tx_line    = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_item(dir_rows[i].op, dir_rows[i].key, dir_rows[i].typed, dir_rows[i].want);
    run_random(250);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: w = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, TRK_UP_MAX, 32'hFFFF_FFFF};
        // All zero: a key-word request queues a zero word and clears the pending word, so it starts no frame.
        1: w = '{32'h0, 32'h0, 32'h0, 32'h0};
        2: w = '{32'h0000_0001, 32'h8000_0000, 32'h0, $urandom()};
        default: w = '{$urandom(), $urandom(), $urandom_range(TRK_UP_MAX, 0), $urandom()};
      endcase
      drain_results();
      repeat (IDLE_SETTLE) @(posedge clk);
      set_key_words(w);
      run_random(210);
    end

    drain_results();
    repeat (IDLE_SETTLE) @(posedge clk);
    if (line_status_q.size() != 0)
      flag_error($sformatf("%0d status words never arrived", line_status_q.size()));
    if (fail_count == 0) begin
      $display("nec_ir_frame_transmitter_top regression: pass");
    end else begin
      $display("nec_ir_frame_transmitter_top regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("nec_ir_frame_transmitter_top regression: fail");
    $finish;
  end

endmodule
